/* hdl/crc8fd_pkg.sv */
// crc8fd_pkg: shared constants, types and helpers of the crc-8 frame deframer
// used by every module under hdl/ but crc8fd_ram; depends on nothing else
package crc8fd_pkg;

    localparam int PAYLOAD_BYTES = 16;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
    localparam int PTR_W         = $clog2(FRAME_BYTES);
    localparam int FILL_W        = $clog2(FRAME_BYTES + 1);

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 4;
    localparam int TDATA_W = 56;

    // frame layout offsets
    localparam logic [PTR_W-1:0] OFF_CMD     = PTR_W'(1);
    localparam logic [PTR_W-1:0] OFF_LEN     = PTR_W'(2);
    localparam logic [PTR_W-1:0] OFF_PAYLOAD = PTR_W'(3);
    localparam logic [PTR_W-1:0] OFF_CRC     = PTR_W'(FRAME_BYTES - 1);

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hBB;
    localparam logic [BYTE_W-1:0] POLY_RESET = 8'h07;

    // configuration register indexes
    localparam logic [0:0] CFG_SYNC = 1'b0;
    localparam logic [0:0] CFG_POLY = 1'b1;

    // result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_CRC_ERR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CRC_RD,
        S_CRC_CHK,
        S_ERR,
        S_EMIT_RD,
        S_EMIT_LD
    } seq_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic clear;
        logic step;
    } crc_ctl_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              busy;
    } seq_status_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [CNT_W-1:0]  payload_count;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] computed_crc;
        logic [BYTE_W-1:0] received_crc;
        logic              last;
    } res_t;

    // circular window address, both operands below FRAME_BYTES
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                   input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W+1)'(FRAME_BYTES)) begin
            s = s - (PTR_W+1)'(FRAME_BYTES);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

/* hdl/crc8fd_ram.sv */
// crc8fd_ram: generic single write, single read synchronous ram
// read data registered; no package dependency
module crc8fd_ram #(
    parameter int DEPTH = 20,
    parameter int WIDTH = 8,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/crc8fd_crc.sv */
// crc8fd_crc: crc-8 accumulator, one byte per step, msb first
// depends on crc8fd_pkg
module crc8fd_crc (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  crc8fd_pkg::crc_ctl_t        ctl,
    input  logic [crc8fd_pkg::BYTE_W-1:0] poly,
    input  logic [crc8fd_pkg::BYTE_W-1:0] data,
    output logic [crc8fd_pkg::BYTE_W-1:0] crc
);
    import crc8fd_pkg::*;

    logic [BYTE_W-1:0] crc_reg;
    logic [BYTE_W-1:0] crc_next;
    logic [BYTE_W-1:0] step_val;

    always_comb begin
        step_val = crc_reg ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (step_val[BYTE_W-1]) begin
                step_val = {step_val[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                step_val = {step_val[BYTE_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        priority if (ctl.clear) begin
            crc_next = '0;
        end else if (ctl.step) begin
            crc_next = step_val;
        end else begin
            crc_next = crc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

/* hdl/crc8fd_seq.sv */
// crc8fd_seq: window sequencer: fill, sync scan, crc pass and result emission
// drives the window ram and the crc unit; depends on crc8fd_pkg
module crc8fd_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [crc8fd_pkg::BYTE_W-1:0] s_byte,
    input  logic [crc8fd_pkg::BYTE_W-1:0] sync_byte,
    output crc8fd_pkg::ram_req_t          ram_req,
    input  logic [crc8fd_pkg::BYTE_W-1:0] ram_rd_data,
    output crc8fd_pkg::crc_ctl_t          crc_ctl,
    input  logic [crc8fd_pkg::BYTE_W-1:0] crc_val,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output crc8fd_pkg::res_t              m_res,
    output crc8fd_pkg::seq_status_t       status
);
    import crc8fd_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0]  off_reg, off_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] rcv_reg, rcv_next;
    res_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;
    logic              load;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        off_next   = off_reg;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        rcv_next   = rcv_reg;
        out_next   = out_reg;
        load       = 1'b0;
        s_tready   = 1'b0;
        ram_req    = '0;
        crc_ctl    = '0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready        = 1'b1;
                ram_req.wr_addr = ring_add(head_reg, PTR_W'(fill_reg));
                ram_req.wr_data = s_byte;
                if (s_tvalid) begin
                    ram_req.wr_en = 1'b1;
                    fill_next     = fill_reg + FILL_W'(1);
                    if (fill_reg == FILL_W'(FRAME_BYTES - 1)) begin
                        off_next   = '0;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = ring_add(head_reg, off_reg);
                state_next      = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (ram_rd_data == sync_byte) begin
                    if (off_reg == '0) begin
                        crc_ctl.clear = 1'b1;
                        off_next      = OFF_CMD;
                        state_next    = S_CRC_RD;
                    end else begin
                        // drop the bytes before the sync byte, wait for refill
                        head_next  = ring_add(head_reg, off_reg);
                        fill_next  = fill_reg - FILL_W'(off_reg);
                        state_next = S_IDLE;
                    end
                end else if (off_reg == OFF_CRC) begin
                    head_next  = '0;
                    fill_next  = '0;
                    state_next = S_IDLE;
                end else begin
                    off_next   = off_reg + PTR_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_CRC_RD: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = ring_add(head_reg, off_reg);
                state_next      = S_CRC_CHK;
            end
            S_CRC_CHK: begin
                if (off_reg == OFF_CMD) begin
                    cmd_next = ram_rd_data;
                end
                if (off_reg == OFF_LEN) begin
                    len_next = ram_rd_data;
                    cnt_next = (ram_rd_data > BYTE_W'(PAYLOAD_BYTES)) ?
                               CNT_W'(PAYLOAD_BYTES) : CNT_W'(ram_rd_data);
                end
                if (off_reg == OFF_CRC) begin
                    rcv_next = ram_rd_data;
                    idx_next = '0;
                    state_next = (crc_val == ram_rd_data) ? S_EMIT_RD : S_ERR;
                end else begin
                    crc_ctl.step = 1'b1;
                    off_next     = off_reg + PTR_W'(1);
                    state_next   = S_CRC_RD;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    load                   = 1'b1;
                    out_next.kind          = KIND_CRC_ERR;
                    out_next.command       = cmd_reg;
                    out_next.length        = len_reg;
                    out_next.payload_count = cnt_reg;
                    out_next.byte_index    = '0;
                    out_next.payload_byte  = '0;
                    out_next.computed_crc  = crc_val;
                    out_next.received_crc  = rcv_reg;
                    out_next.last          = 1'b1;
                    // drop the leading sync byte only
                    head_next  = ring_add(head_reg, PTR_W'(1));
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = ring_add(head_reg, OFF_PAYLOAD + PTR_W'(idx_reg));
                state_next      = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    load                   = 1'b1;
                    out_next.kind          = KIND_DATA;
                    out_next.command       = cmd_reg;
                    out_next.length        = len_reg;
                    out_next.payload_count = cnt_reg;
                    out_next.byte_index    = idx_reg;
                    out_next.payload_byte  = ram_rd_data;
                    out_next.computed_crc  = crc_val;
                    out_next.received_crc  = rcv_reg;
                    out_next.last          = (idx_reg == IDX_W'(PAYLOAD_BYTES - 1));
                    if (idx_reg == IDX_W'(PAYLOAD_BYTES - 1)) begin
                        head_next  = '0;
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg <= off_next;
        idx_reg <= idx_next;
        cmd_reg <= cmd_next;
        len_reg <= len_next;
        cnt_reg <= cnt_next;
        rcv_reg <= rcv_next;
        out_reg <= out_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign m_res       = out_reg;
    assign status.fill = fill_reg;
    assign status.busy = (state_reg != S_IDLE);

endmodule

/* hdl/crc8_frame_deframer.sv */
// crc8_frame_deframer: top level, config registers, window ram, crc unit, sequencer
// depends on crc8fd_pkg, crc8fd_ram, crc8fd_crc and crc8fd_seq
//
//  channel  | dir | tdata                 | tuser | tlast
//  ---------+-----+-----------------------+-------+-------------------
//  s_       | in  | rx_byte               | -     | -
//  m_       | out | see m_tdata below     | kind  | last
//  cfg_     | in  | write only: 0 sync_byte, 1 crc_polynomial
//
// a full window goes through a sync scan (each byte read through the ram read
// port), a crc pass, then result emission; no new byte is taken until that ends
// output stalls hold the sequencer in its error or emit state; reset is synchronous
// and empties the window, no clearing pass is needed
module crc8_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] command, [15:8] length, [20:16] payload_count, [24:21] byte_index,
    // [32:25] payload_byte, [40:33] computed_crc, [48:41] received_crc, zero above
    output logic [55:0] m_tdata,
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wr_data
);
    import crc8fd_pkg::*;

    logic [BYTE_W-1:0] sync_reg;
    logic [BYTE_W-1:0] poly_reg;
    ram_req_t          ram_req;
    logic [BYTE_W-1:0] ram_rd_data;
    crc_ctl_t          crc_ctl;
    logic [BYTE_W-1:0] crc_val;
    res_t              res;
    seq_status_t       status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= SYNC_RESET;
            poly_reg <= POLY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SYNC: sync_reg <= cfg_wr_data;
                CFG_POLY: poly_reg <= cfg_wr_data;
                default:  sync_reg <= sync_reg;
            endcase
        end
    end

    // reads and writes never share a cycle: writes happen only while idle
    crc8fd_ram #(
        .DEPTH(FRAME_BYTES),
        .WIDTH(BYTE_W),
        .AW   (PTR_W)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_req.wr_en),
        .wr_addr(ram_req.wr_addr),
        .wr_data(ram_req.wr_data),
        .rd_en  (ram_req.rd_en),
        .rd_addr(ram_req.rd_addr),
        .rd_data(ram_rd_data)
    );

    crc8fd_crc u_crc (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (crc_ctl),
        .poly   (poly_reg),
        .data   (ram_rd_data),
        .crc    (crc_val)
    );

    crc8fd_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata),
        .sync_byte  (sync_reg),
        .ram_req    (ram_req),
        .ram_rd_data(ram_rd_data),
        .crc_ctl    (crc_ctl),
        .crc_val    (crc_val),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (res),
        .status     (status)
    );

    assign m_tdata = {7'd0, res.received_crc, res.computed_crc, res.payload_byte,
                      res.byte_index, res.payload_count, res.length, res.command};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (status.fill < FILL_W'(FRAME_BYTES)))
        else $error("window fill out of range while taking bytes");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_CRC_ERR)) |->
            (m_tlast && (m_tdata[40:33] != m_tdata[48:41])))
        else $error("error result not last or crc matches");

    a_data_crc_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_DATA)) |->
            ((m_tdata[40:33] == m_tdata[48:41]) &&
             (m_tlast == (m_tdata[24:21] == IDX_W'(PAYLOAD_BYTES - 1)))))
        else $error("payload result with bad crc or misplaced last");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.busy)
        else $error("request taken while sequencer busy");
`endif

endmodule

/* bench/tb_crc8_frame_deframer.sv */
`timescale 1ns / 100ps
// tb_crc8_frame_deframer: self-checking bench for the crc-8 frame deframer, with a
// frame-level scoreboard, random stalls on both streams and several register settings
// depends on crc8fd_pkg and the crc8_frame_deframer rtl

module tb_crc8_frame_deframer;
    import crc8fd_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_BYTES   = 48;

    class deframe_scoreboard;
        logic [7:0] window [FRAME_BYTES];
        int         fill;
        logic [7:0] sync_val;
        logic [7:0] poly_val;
        res_t       pending_res [$];
        int         mismatches;
        int         good_frames;
        int         bad_frames;
        int         results_seen;

        function new();
            fill         = 0;
            sync_val     = SYNC_RESET;
            poly_val     = POLY_RESET;
            mismatches   = 0;
            good_frames  = 0;
            bad_frames   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic idx, logic [7:0] v);
            if (idx == CFG_SYNC) begin
                sync_val = v;
            end else begin
                poly_val = v;
            end
        endfunction

        // one byte of a msb-first crc-8, no reflection
        function logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            for (int k = 0; k < 8; k++) begin
                c = c[7] ? ((c << 1) ^ poly_val) : (c << 1);
            end
            return c;
        endfunction

        function void drop_front(int n);
            if (n >= fill) begin
                fill = 0;
                return;
            end
            for (int k = 0; k < fill - n; k++) begin
                window[k] = window[k + n];
            end
            fill -= n;
        endfunction

        // accepted rx byte: update the window and queue the results it causes
        function void take_rx_byte(logic [7:0] b);
            int         s;
            logic [7:0] crc;
            res_t       r;
            if (fill >= FRAME_BYTES) fill = 0;
            window[fill] = b;
            fill++;
            if (fill < FRAME_BYTES) return;

            s = 0;
            while (s < FRAME_BYTES && window[s] != sync_val) s++;
            if (s >= FRAME_BYTES) begin
                fill = 0;
                return;
            end
            if (s > 0) begin
                drop_front(s);
                return;
            end

            crc = 8'h00;
            for (int i = 1; i < FRAME_BYTES - 1; i++) begin
                crc = crc_byte(crc, window[i]);
            end
            r.command       = window[OFF_CMD];
            r.length        = window[OFF_LEN];
            r.payload_count = (window[OFF_LEN] > PAYLOAD_BYTES) ? CNT_W'(PAYLOAD_BYTES)
                                                                : CNT_W'(window[OFF_LEN]);
            r.computed_crc  = crc;
            r.received_crc  = window[OFF_CRC];

            if (crc != r.received_crc) begin
                r.kind         = KIND_CRC_ERR;
                r.byte_index   = '0;
                r.payload_byte = '0;
                r.last         = 1'b1;
                pending_res.push_back(r);
                bad_frames++;
                drop_front(1);
                return;
            end

            r.kind = KIND_DATA;
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                r.byte_index   = IDX_W'(i);
                r.payload_byte = window[OFF_PAYLOAD + i];
                r.last         = (i == PAYLOAD_BYTES - 1);
                pending_res.push_back(r);
            end
            good_frames++;
            fill = 0;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [55:0] data, logic kind, logic last);
            res_t e;
            results_seen++;
            if (pending_res.size() == 0) begin
                $error("result with nothing pending: tdata 0x%0h kind %0d", data, kind);
                mismatches++;
                return;
            end
            e = pending_res.pop_front();
            compare_field("kind",          e.kind,          kind);
            compare_field("command",       e.command,       data[7:0]);
            compare_field("length",        e.length,        data[15:8]);
            compare_field("payload_count", e.payload_count, data[20:16]);
            compare_field("byte_index",    e.byte_index,    data[24:21]);
            compare_field("payload_byte",  e.payload_byte,  data[32:25]);
            compare_field("computed_crc",  e.computed_crc,  data[40:33]);
            compare_field("received_crc",  e.received_crc,  data[48:41]);
            compare_field("tdata padding", 0,               data[55:49]);
            compare_field("last",          e.last,          last);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [7:0]  cfg_wr_data;

    deframe_scoreboard sb;
    logic [7:0]        tx_q [$];
    bit                burst_mode;
    int                bytes_sent  = 0;
    int                idle_cycles = 0;

    crc8_frame_deframer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(int longest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, longest);
    endfunction

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                return 8'h00;
            end
            1: begin
                return 8'(PAYLOAD_BYTES);
            end
            2: begin
                return 8'hFF;
            end
            3, 4: begin
                return 8'($urandom_range(1, PAYLOAD_BYTES + 1));
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // build a frame for the current sync byte and polynomial, keep its first bytes
    function automatic void queue_frame(logic [7:0] cmd, logic [7:0] len, bit corrupt,
                                        bit ramp, int keep);
        logic [7:0] f [$];
        logic [7:0] crc;
        logic [7:0] p;
        f.push_back(sb.sync_val);
        f.push_back(cmd);
        f.push_back(len);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (ramp) begin
                p = 8'(i * 17);
            end else if ($urandom_range(0, 11) == 0) begin
                p = sb.sync_val;
            end else begin
                p = 8'($urandom_range(0, 255));
            end
            f.push_back(p);
        end
        crc = 8'h00;
        for (int i = 1; i < FRAME_BYTES - 1; i++) begin
            crc = sb.crc_byte(crc, f[i]);
        end
        if (corrupt) crc ^= 8'h01 << $urandom_range(0, 7);
        f.push_back(crc);
        for (int i = 0; i < keep; i++) begin
            tx_q.push_back(f[i]);
        end
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = burst_mode ? 0 : pick_gap(40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.take_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (tx_q.size() > 0) begin
            push_byte(tx_q.pop_front());
        end
    endtask

    task automatic run_random(int n);
        int start;
        int r;
        start = bytes_sent;
        while (bytes_sent - start < n) begin
            r          = $urandom_range(0, 99);
            burst_mode = ($urandom_range(0, 4) == 0);
            if (r < 60) begin
                queue_frame(8'($urandom_range(0, 255)), pick_len(), 1'b0, 1'b0, FRAME_BYTES);
            end else if (r < 75) begin
                queue_frame(8'($urandom_range(0, 255)), pick_len(), 1'b1, 1'b0, FRAME_BYTES);
            end else if (r < 88) begin
                queue_frame(8'($urandom_range(0, 255)), pick_len(), 1'b0, 1'b0,
                            $urandom_range(1, FRAME_BYTES - 1));
            end else begin
                repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(0, 255)));
            end
            send_queued();
        end
    endtask

    // let every expected result arrive, then give a scan that yields nothing time to end
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_res.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [7:0] sync_v, input logic [7:0] poly_v);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_SYNC;
        cfg_wr_data <= sync_v;
        @(posedge aclk);
        sb.write_reg(CFG_SYNC, sync_v);
        cfg_addr    <= CFG_POLY;
        cfg_wr_data <= poly_v;
        @(posedge aclk);
        sb.write_reg(CFG_POLY, poly_v);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int hi;
        int lo;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            hi = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
            lo = pick_gap(60);
            m_tready <= 1'b1;
            repeat (hi) @(posedge aclk);
            if (lo > 0) begin
                m_tready <= 1'b0;
                repeat (lo) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
            $display("crc8_frame_deframer verification failed");
            $finish;
        end
    end

    initial begin
        sb          = new();
        burst_mode  = 1'b0;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'h00;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= CFG_SYNC;
        cfg_wr_data <= 8'h00;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // two stray bytes force a realignment, then a clamped good frame
        // and a bad crc frame, both carrying a payload ramp from 0x00 to 0xff
        tx_q.push_back(8'h00);
        tx_q.push_back(8'hFF);
        queue_frame(8'h00, 8'hFF, 1'b0, 1'b1, FRAME_BYTES);
        queue_frame(8'hFF, 8'(PAYLOAD_BYTES), 1'b1, 1'b1, FRAME_BYTES);
        send_queued();
        run_random(PHASE_BYTES);
        drain();

        write_regs(8'h00, 8'hFF);
        run_random(PHASE_BYTES);
        drain();

        write_regs(8'hFF, 8'h00);
        run_random(PHASE_BYTES);
        drain();

        write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(PHASE_BYTES);
        drain();

        write_regs(SYNC_RESET, POLY_RESET);
        run_random(PHASE_BYTES);
        drain();

        $display("sent %0d bytes over 5 sync/polynomial settings", bytes_sent);
        $display("checked %0d results: %0d good frames, %0d crc mismatches",
                 sb.results_seen, sb.good_frames, sb.bad_frames);
        if (sb.mismatches == 0) begin
            $display("crc8_frame_deframer verification clean");
        end else begin
            $display("crc8_frame_deframer verification failed");
        end
        $finish;
    end

endmodule
